FILE: rtl/ramb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route adjacency matrix builder package
// Shared sizes, codes and item types for the matrix builder.
// ----------------------------------------------------------------------------
package ramb_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VTX_W        = 6;
	localparam int OUT_ROW_W    = 32;
	localparam int ROW_IDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	localparam logic FUNC_STOP = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	localparam logic [VTX_W-1:0] VERTEX_COUNT_RESET = VTX_W'(32);

	typedef logic [MAX_VERTICES-1:0] row_t;

	typedef struct packed {
		logic             func;
		logic [VTX_W-1:0] vertex;
		logic             last_of_route;
	} item_t;

	typedef struct packed {
		logic                 status;
		logic [OUT_ROW_W-1:0] neighbor_row;
		logic [OUT_ROW_W-1:0] coroute_row;
	} result_t;

endpackage

FILE: rtl/ramb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one stop or row read per beat.
// ----------------------------------------------------------------------------
interface ramb_in_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [ramb_pkg::VTX_W-1:0] vertex;
	logic                      last_of_route;

	modport source (output valid, output func, output vertex, output last_of_route,
		input ready);
	modport sink (input valid, input func, input vertex, input last_of_route,
		output ready);
endinterface

FILE: rtl/ramb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one status and two matrix rows per beat.
// ----------------------------------------------------------------------------
interface ramb_out_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [ramb_pkg::OUT_ROW_W-1:0] neighbor_row;
	logic [ramb_pkg::OUT_ROW_W-1:0] coroute_row;

	modport source (output valid, output status, output neighbor_row,
		output coroute_row, input ready);
	modport sink (input valid, input status, input neighbor_row,
		input coroute_row, output ready);
endinterface

FILE: rtl/ramb_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the vertex count register write data.
// ----------------------------------------------------------------------------
interface ramb_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ramb_pkg::VTX_W-1:0] vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

FILE: rtl/ramb_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix state and single pass update
// Holds both bit matrices and the current route, applies one item per cycle when fired.
// ----------------------------------------------------------------------------
module ramb_matrix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  ramb_pkg::item_t             item,
	input  logic [ramb_pkg::CNT_W-1:0]  usable_cnt,
	output ramb_pkg::result_t           result
);

	ramb_pkg::row_t nbr_q [ramb_pkg::MAX_VERTICES];
	ramb_pkg::row_t co_q  [ramb_pkg::MAX_VERTICES];
	ramb_pkg::row_t seen_q;
	logic [ramb_pkg::VTX_W-1:0] prev_q;

	logic                           in_range;
	logic                           is_stop;
	logic                           link_nbr;
	logic [ramb_pkg::VTX_W-1:0]     vm1;
	logic [ramb_pkg::ROW_IDX_W-1:0] rd_idx;
	ramb_pkg::row_t                 vsel;
	ramb_pkg::row_t                 psel;
	ramb_pkg::row_t                 cnt_mask;
	ramb_pkg::row_t                 nbr_rd;
	ramb_pkg::row_t                 co_rd;

	assign in_range = (item.vertex != '0) &&
		({1'b0, item.vertex} <= (ramb_pkg::VTX_W + 1)'(usable_cnt));
	assign is_stop  = (item.func == ramb_pkg::FUNC_STOP);
	assign link_nbr = (prev_q != '0) && (prev_q != item.vertex) &&
		({1'b0, prev_q} <= (ramb_pkg::VTX_W + 1)'(ramb_pkg::MAX_VERTICES));
	assign vm1      = item.vertex - ramb_pkg::VTX_W'(1);
	assign rd_idx   = vm1[ramb_pkg::ROW_IDX_W-1:0];

	// Row select decoders for the stop vertex and the previous stop, and the vertex count mask.
	always_comb begin
		for (int r = 0; r < ramb_pkg::MAX_VERTICES; r++) begin
			vsel[r]     = (item.vertex == ramb_pkg::VTX_W'(r + 1));
			psel[r]     = (prev_q == ramb_pkg::VTX_W'(r + 1));
			cnt_mask[r] = (ramb_pkg::CNT_W'(r) < usable_cnt);
		end
	end

	assign nbr_rd = nbr_q[rd_idx] & cnt_mask;
	assign co_rd  = co_q[rd_idx] & cnt_mask;

	always_comb begin
		result.status       = in_range ? ramb_pkg::STATUS_OK : ramb_pkg::STATUS_RANGE;
		result.neighbor_row = '0;
		result.coroute_row  = '0;
		if (!is_stop && in_range) begin
			for (int j = 0; j < ramb_pkg::OUT_ROW_W; j++) begin
				if (j < ramb_pkg::MAX_VERTICES) begin
					result.neighbor_row[j] = nbr_rd[j];
					result.coroute_row[j]  = co_rd[j];
				end
			end
		end
	end

	// A stop updates its own row and its column in the rows of the route's earlier stops at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ramb_pkg::MAX_VERTICES; r++) begin
				nbr_q[r] <= '0;
				co_q[r]  <= '0;
			end
			seen_q <= '0;
			prev_q <= '0;
		end else if (fire && is_stop) begin
			if (in_range) begin
				for (int r = 0; r < ramb_pkg::MAX_VERTICES; r++) begin
					if (vsel[r]) begin
						co_q[r] <= co_q[r] | (seen_q & ~vsel);
						if (link_nbr) begin
							nbr_q[r] <= nbr_q[r] | psel;
						end
					end else begin
						if (seen_q[r]) begin
							co_q[r] <= co_q[r] | vsel;
						end
						if (link_nbr && psel[r]) begin
							nbr_q[r] <= nbr_q[r] | vsel;
						end
					end
				end
			end
			if (item.last_of_route) begin
				seen_q <= '0;
				prev_q <= '0;
			end else if (in_range) begin
				seen_q <= seen_q | vsel;
				prev_q <= item.vertex;
			end
		end
	end

endmodule

FILE: rtl/route_adjacency_matrix_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route adjacency matrix builder
// Builds neighbor and co-route bit matrices from route stops, reads rows.
// ----------------------------------------------------------------------------
//  Channel    Dir  Beat contents
//  item_in    in   func, vertex, last_of_route
//  result_out out  status, neighbor_row, coroute_row
//  cfg        in   vertex_count
//
// Each item is held in the input register, where both matrices are read or
// updated, and then lands in the result register; one item per cycle while
// the result is not stalled.
// Reset clears both matrices, the current route and sets vertex_count to 32.
// A stalled result holds the pipeline; the input register refills as soon
// as its item moves on.
// ----------------------------------------------------------------------------
module route_adjacency_matrix_builder_top (
	input  logic          clk,
	input  logic          arst_n,
	ramb_in_if.sink       item_in,
	ramb_out_if.source    result_out,
	ramb_cfg_if.sink      cfg
);

	logic                        valid_s1;
	ramb_pkg::item_t             item_s1;
	logic                        out_valid_q;
	ramb_pkg::result_t           result_q;
	ramb_pkg::result_t           result_d;
	logic [ramb_pkg::VTX_W-1:0]  vertex_count_q;
	logic [ramb_pkg::CNT_W-1:0]  usable_cnt;
	logic                        advance;
	logic                        fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= ramb_pkg::VERTEX_COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	always_comb begin
		if ((ramb_pkg::CNT_W + ramb_pkg::VTX_W)'(vertex_count_q) >
				(ramb_pkg::CNT_W + ramb_pkg::VTX_W)'(ramb_pkg::MAX_VERTICES)) begin
			usable_cnt = ramb_pkg::CNT_W'(ramb_pkg::MAX_VERTICES);
		end else begin
			usable_cnt = ramb_pkg::CNT_W'(vertex_count_q);
		end
	end

	assign advance       = !out_valid_q || result_out.ready;
	assign fire          = valid_s1 && advance;
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1.func          <= item_in.func;
			item_s1.vertex        <= item_in.vertex;
			item_s1.last_of_route <= item_in.last_of_route;
		end
	end

	ramb_matrix u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.usable_cnt (usable_cnt),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.status       = result_q.status;
	assign result_out.neighbor_row = result_q.neighbor_row;
	assign result_out.coroute_row  = result_q.coroute_row;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route adjacency matrix builder testbench
// Sends route stops and row reads over the item channel, models the neighbor
// and co-route matrices alongside the block and compares every result beat.
// Item and result channels idle at random, and the vertex count is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RUN_LIMIT   = 400000;
	localparam int PHASE_ITEMS = 240;

	logic clk;
	logic arst_n;

	ramb_in_if  item_if();
	ramb_out_if res_if();
	ramb_cfg_if cfg_if();

	route_adjacency_matrix_builder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	// Predicted state of the block.
	ramb_pkg::row_t             neighbor_rows [ramb_pkg::MAX_VERTICES];
	ramb_pkg::row_t             coroute_rows [ramb_pkg::MAX_VERTICES];
	ramb_pkg::row_t             route_members;
	int                         prev_stop;
	logic [ramb_pkg::VTX_W-1:0] vtx_count;

	ramb_pkg::result_t pending_results [$];
	int                error_count;
	int                cycle_count;
	bit                no_idle;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int usable_count();
		return (vtx_count > ramb_pkg::MAX_VERTICES) ? ramb_pkg::MAX_VERTICES : int'(vtx_count);
	endfunction

	// Applies one accepted item to the predicted matrices and returns its result.
	function automatic ramb_pkg::result_t apply_item(ramb_pkg::item_t it);
		ramb_pkg::result_t r;
		int                cnt;
		int                v;
		bit                in_range;
		ramb_pkg::row_t    mask;

		cnt      = usable_count();
		v        = int'(it.vertex);
		in_range = (v >= 1) && (v <= cnt);
		r        = '0;
		r.status = in_range ? ramb_pkg::STATUS_OK : ramb_pkg::STATUS_RANGE;
		if (it.func == ramb_pkg::FUNC_READ) begin
			if (in_range) begin
				mask = (cnt >= ramb_pkg::MAX_VERTICES) ? '1 :
					ramb_pkg::row_t'((64'd1 << cnt) - 1);
				r.neighbor_row = neighbor_rows[v-1] & mask;
				r.coroute_row  = coroute_rows[v-1] & mask;
			end
		end else begin
			if (in_range) begin
				if (prev_stop != 0 && prev_stop != v) begin
					neighbor_rows[prev_stop-1][v-1] = 1'b1;
					neighbor_rows[v-1][prev_stop-1] = 1'b1;
				end
				for (int u = 1; u <= ramb_pkg::MAX_VERTICES; u++) begin
					if (u != v && route_members[u-1]) begin
						coroute_rows[u-1][v-1] = 1'b1;
						coroute_rows[v-1][u-1] = 1'b1;
					end
				end
				route_members[v-1] = 1'b1;
				prev_stop = v;
			end
			if (it.last_of_route) begin
				route_members = '0;
				prev_stop     = 0;
			end
		end
		return r;
	endfunction

	task automatic send_item(input logic f, input logic [ramb_pkg::VTX_W-1:0] v,
		input logic last);
		int              gap;
		ramb_pkg::item_t it;

		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid         <= 1'b1;
		item_if.func          <= f;
		item_if.vertex        <= v;
		item_if.last_of_route <= last;
		it = '{func: f, vertex: v, last_of_route: last};
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		pending_results.push_back(apply_item(it));
	endtask

	// Stops sending and waits until every predicted result has been checked.
	task automatic wait_idle();
		item_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [ramb_pkg::VTX_W-1:0] count);
		wait_idle();
		cfg_if.valid        <= 1'b1;
		cfg_if.vertex_count <= count;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		vtx_count = count;
		@(posedge clk);
	endtask

	function automatic logic [ramb_pkg::VTX_W-1:0] pick_vertex();
		return ramb_pkg::VTX_W'($urandom_range(1, usable_count()));
	endfunction

	// Result side: random stalls, then every beat is checked against the oldest
	// prediction.
	initial begin : result_checker
		int                stall;
		ramb_pkg::result_t exp_res;

		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (res_if.valid !== 1'b1) @(posedge clk);
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction pending");
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (res_if.status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, res_if.status);
					error_count++;
				end
				if (res_if.neighbor_row !== exp_res.neighbor_row) begin
					$error("neighbor_row: expected %h, got %h", exp_res.neighbor_row,
						res_if.neighbor_row);
					error_count++;
				end
				if (res_if.coroute_row !== exp_res.coroute_row) begin
					$error("coroute_row: expected %h, got %h", exp_res.coroute_row,
						res_if.coroute_row);
					error_count++;
				end
			end
		end
	end

	task automatic test_directed_extremes();
		send_item(ramb_pkg::FUNC_READ, 6'd1, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd32, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd0, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd33, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd63, 1'b1);
		send_item(ramb_pkg::FUNC_STOP, 6'd1, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd32, 1'b0);
		// A repeated stop links nothing to itself.
		send_item(ramb_pkg::FUNC_STOP, 6'd32, 1'b0);
		// A rejected stop still closes the route.
		send_item(ramb_pkg::FUNC_STOP, 6'd0, 1'b1);
		send_item(ramb_pkg::FUNC_STOP, 6'd5, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd6, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd1, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd32, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd5, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd0, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd33, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd63, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd7, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd7, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd2, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd3, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd2, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd2, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd3, 1'b0);
	endtask

	// Lowering the count hides stored bits above it; raising it shows them again.
	task automatic test_count_lowered();
		write_vertex_count(6'd4);
		send_item(ramb_pkg::FUNC_READ, 6'd32, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd5, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd1, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd2, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd4, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd5, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd4, 1'b0);
		write_vertex_count(6'd1);
		send_item(ramb_pkg::FUNC_STOP, 6'd1, 1'b0);
		send_item(ramb_pkg::FUNC_STOP, 6'd1, 1'b1);
		send_item(ramb_pkg::FUNC_READ, 6'd1, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd2, 1'b0);
		write_vertex_count(6'd32);
		send_item(ramb_pkg::FUNC_READ, 6'd1, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd4, 1'b0);
		send_item(ramb_pkg::FUNC_READ, 6'd32, 1'b0);
	endtask

	task automatic test_random_routes();
		logic [ramb_pkg::VTX_W-1:0] counts [8];
		int                         sent;
		int                         kind;
		int                         len;
		int                         pause_at;

		counts = '{6'd32, 6'd1, 6'd2, 6'd13, 6'd31, 6'd32, 6'd0, 6'd0};
		counts[6] = ramb_pkg::VTX_W'($urandom_range(1, ramb_pkg::MAX_VERTICES));
		counts[7] = ramb_pkg::VTX_W'($urandom_range(1, ramb_pkg::MAX_VERTICES));
		foreach (counts[p]) begin
			write_vertex_count(counts[p]);
			sent     = 0;
			pause_at = $urandom_range(40, PHASE_ITEMS - 40);
			while (sent < PHASE_ITEMS) begin
				no_idle = ($urandom_range(0, 4) == 0);
				kind    = $urandom_range(0, 99);
				if (kind < 65) begin
					// A whole route; now and then one is left open so the next
					// route continues it.
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						send_item(ramb_pkg::FUNC_STOP, pick_vertex(),
							(i == len - 1) && ($urandom_range(0, 19) != 0));
					end
					sent += len;
				end else if (kind < 85) begin
					send_item(ramb_pkg::FUNC_READ, pick_vertex(), 1'($urandom_range(0, 1)));
					sent++;
				end else begin
					send_item(1'($urandom_range(0, 1)),
						ramb_pkg::VTX_W'($urandom_range(0, 63)),
						1'($urandom_range(0, 1)));
					sent++;
				end
				if (sent >= pause_at && pause_at > 0) begin
					pause_at = 0;
					wait_idle();
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		error_count   = 0;
		no_idle       = 1'b0;
		route_members = '0;
		prev_stop     = 0;
		vtx_count     = ramb_pkg::VERTEX_COUNT_RESET;
		foreach (neighbor_rows[i]) begin
			neighbor_rows[i] = '0;
			coroute_rows[i]  = '0;
		end
		arst_n                <= 1'b0;
		item_if.valid         <= 1'b0;
		item_if.func          <= ramb_pkg::FUNC_STOP;
		item_if.vertex        <= '0;
		item_if.last_of_route <= 1'b0;
		cfg_if.valid          <= 1'b0;
		cfg_if.vertex_count   <= ramb_pkg::VERTEX_COUNT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_count_lowered();
		test_random_routes();

		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
